>>> design/bc_pkg.sv
// Shared types and constants for the binomial coefficient unit.
// No dependencies; imported by binomial_coefficient_unit, coefficient_checker and the testbench.
`default_nettype none

package bc_pkg;

  // Argument and result widths, and the product width the datapath needs
  localparam int ARG_W  = 16;
  localparam int RES_W  = 64;
  localparam int PROD_W = RES_W + ARG_W;
  localparam int CNT_W  = $clog2(PROD_W);

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_OVERFLOW = 2'd1,
    STATUS_RANGE    = 2'd2
  } status_t;

  // Input word
  typedef struct packed {
    logic [ARG_W-1:0] n;
    logic [ARG_W-1:0] k;
  } operand_t;

  // Result word
  typedef struct packed {
    logic [RES_W-1:0] coefficient;
    status_t          status;
  } result_t;

endpackage

`default_nettype wire

>>> design/binomial_coefficient_unit.sv
// Binomial coefficient unit: C(n,k) by the multiplicative rule on one shared adder.
// Depends on bc_pkg (widths, status codes, word structs).
//
//  channel  | signals              | handshake
//  ---------+----------------------+-------------------------------------
//  input    | start, busy, operand | word taken when start && !busy
//  result   | done, result         | done high one cycle, no backpressure
//
// Each step i = 1..min(k, n-k) forms b*(n-i+1) by shift-add and divides it
// exactly by i with a restoring divider, all on one adder. An overflow in any
// step ends the item with STATUS_OVERFLOW; k > n is answered from idle as a range error.
// Reset is synchronous and returns the sequencer to idle with no result pending.
// The receiver cannot stall; a result shows for exactly one cycle.
`default_nettype none

module binomial_coefficient_unit
  import bc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  input  wire operand_t operand,
  output logic          done,
  output result_t       result
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_MUL   = 5'b00100,
    S_DIV   = 5'b01000,
    S_WB    = 5'b10000
  } state_t;

  state_t            state;
  logic [ARG_W-1:0]  m_lim;    // min(k, n-k)
  logic [ARG_W-1:0]  idx;      // step index i
  logic [ARG_W-1:0]  num;      // n - i + 1
  logic [ARG_W-1:0]  mulsh;    // multiplier bits, MSB first
  logic [RES_W-1:0]  b;        // partial coefficient C(n, i-1)
  logic [PROD_W-1:0] acc;      // product, then quotient
  logic [ARG_W-1:0]  rem;      // divider remainder
  logic [CNT_W-1:0]  cnt;

  logic [ARG_W-1:0]  n_minus_k;
  logic [PROD_W-1:0] opa;
  logic [PROD_W-1:0] opb;
  logic              sub;
  logic [PROD_W:0]   sum;
  logic              borrow;
  logic [ARG_W:0]    trial;
  logic [ARG_W-1:0]  rem_next;

  assign busy      = (state != S_IDLE);
  assign n_minus_k = operand.n - operand.k;
  assign trial     = {rem, acc[PROD_W-1]};

  // Shared add/subtract unit
  always_comb begin
    opa = '0;
    opb = '0;
    sub = 1'b0;
    case (state)
      S_MUL: begin
        opa = {acc[PROD_W-2:0], 1'b0};
        opb = mulsh[ARG_W-1] ? PROD_W'(b) : '0;
      end
      S_DIV: begin
        opa = PROD_W'(trial);
        opb = PROD_W'(idx);
        sub = 1'b1;
      end
      default: begin
        opa = '0;
      end
    endcase
    sum = {1'b0, opa} + (sub ? ~{1'b0, opb} : {1'b0, opb}) + (PROD_W + 1)'(sub);
  end

  // Restoring division: keep the trial value when the subtraction borrows
  assign borrow   = sum[PROD_W];
  assign rem_next = borrow ? trial[ARG_W-1:0] : sum[ARG_W-1:0];

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            if (operand.k > operand.n) begin
              result.coefficient <= '0;
              result.status      <= STATUS_RANGE;
              done               <= 1'b1;
            end else begin
              m_lim <= (operand.k < n_minus_k) ? operand.k : n_minus_k;
              num   <= operand.n;
              idx   <= ARG_W'(1);
              b     <= RES_W'(1);
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (idx > m_lim) begin
            result.coefficient <= b;
            result.status      <= STATUS_OK;
            done               <= 1'b1;
            state              <= S_IDLE;
          end else begin
            acc   <= '0;
            mulsh <= num;
            cnt   <= CNT_W'(ARG_W - 1);
            state <= S_MUL;
          end
        end
        S_MUL: begin
          acc   <= sum[PROD_W-1:0];
          mulsh <= {mulsh[ARG_W-2:0], 1'b0};
          if (cnt == '0) begin
            rem   <= '0;
            cnt   <= CNT_W'(PROD_W - 1);
            state <= S_DIV;
          end else begin
            cnt <= cnt - CNT_W'(1);
          end
        end
        S_DIV: begin
          acc <= {acc[PROD_W-2:0], ~borrow};
          rem <= rem_next;
          if (cnt == '0) begin
            state <= S_WB;
          end else begin
            cnt <= cnt - CNT_W'(1);
          end
        end
        S_WB: begin
          // partial values never decrease, so any overflow is final
          if (acc[PROD_W-1:RES_W] != '0) begin
            result.coefficient <= '1;
            result.status      <= STATUS_OVERFLOW;
            done               <= 1'b1;
            state              <= S_IDLE;
          end else begin
            b     <= acc[RES_W-1:0];
            idx   <= idx + ARG_W'(1);
            num   <= num - ARG_W'(1);
            state <= S_CHECK;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // k > n answers in the next cycle with a range error
  a_range_err: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (operand.k > operand.n)) |=>
      (done && result.status == STATUS_RANGE && result.coefficient == '0))
    else $error("range error not reported");

  // a valid pair starts the sequencer
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (operand.k <= operand.n)) |=> busy)
    else $error("accepted word did not start the sequencer");

  // divisor is never zero while dividing
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (idx != '0))
    else $error("division by zero step index");

  // a computed result follows a busy cycle
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != STATUS_RANGE) |-> $past(busy))
    else $error("result without work");

  // step index never runs past its limit while multiplying
  a_idx_limit: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> (idx <= m_lim && idx != '0))
    else $error("step index out of range");
`endif

endmodule

`default_nettype wire

>>> test/coefficient_checker.sv
// Checker for binomial_coefficient_unit: watches the operand and result channels,
// predicts C(n,k) with status for every accepted word, and compares in order.
// Depends on bc_pkg (widths, status codes, word structs).
`timescale 1ns / 1ps

module coefficient_checker
  import bc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     busy,
  input  operand_t operand,
  input  logic     done,
  input  result_t  result,
  output int       outstanding,
  output int       mismatches
);

  result_t expected_results[$];
  result_t want;

  // Multiplicative rule with the common factor of b and i divided out first,
  // so b * (n-i+1) / i never needs more than the result width
  function automatic result_t binomial_expected(input operand_t w);
    logic [63:0] nn, kk, m, i, b, a, r, t, bq, iq, q, lim;
    result_t res;
    nn = 64'(w.n);
    kk = 64'(w.k);
    lim = '0;
    lim[RES_W-1:0] = '1;
    // k above n is a range error
    if (kk > nn) begin
      res.coefficient = '0;
      res.status = STATUS_RANGE;
      return res;
    end
    m = (kk < nn - kk) ? kk : nn - kk;
    b = 64'd1;
    for (i = 64'd1; i <= m; i++) begin
      a = b;
      r = i;
      while (r != 0) begin
        t = a % r;
        a = r;
        r = t;
      end
      bq = b / a;
      iq = i / a;
      q = (nn - i + 64'd1) / iq;
      // partial values only grow, so the first overflow is final
      if (q != 0 && bq > lim / q) begin
        res.coefficient = '1;
        res.status = STATUS_OVERFLOW;
        return res;
      end
      b = bq * q;
    end
    res.coefficient = b[RES_W-1:0];
    res.status = STATUS_OK;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR %0t ns: %s", $time, what);
    mismatches++;
  endtask

  // Queue a prediction per accepted word, check each strobed result against the oldest
  always @(posedge clk) begin
    if (rst) begin
      expected_results.delete();
      outstanding <= 0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(binomial_expected(operand));
      end
      if (done) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: coefficient %0h status %0d",
                                    result.coefficient, result.status));
        end else begin
          want = expected_results.pop_front();
          if (result.coefficient !== want.coefficient) begin
            report_mismatch($sformatf("coefficient %0h, expected %0h",
                                      result.coefficient, want.coefficient));
          end
          if (result.status !== want.status) begin
            report_mismatch($sformatf("status %0d, expected %0d",
                                      result.status, want.status));
          end
        end
      end
      outstanding <= expected_results.size();
    end
  end

endmodule

>>> test/binomial_coefficient_unit_tb.sv
// Testbench top for binomial_coefficient_unit: clock, reset, directed and random
// operand words with random gaps, and the final verdict.
// Depends on bc_pkg, binomial_coefficient_unit and coefficient_checker.
`timescale 1ns / 1ps

module binomial_coefficient_unit_tb;
  import bc_pkg::*;

  localparam int ARG_MAX      = (1 << ARG_W) - 1;
  localparam int RANDOM_WORDS = 120;
  localparam int ITEM_CYCLES  = 4096 + 6 + 2;
  localparam int CYCLE_LIMIT  = (25 + RANDOM_WORDS) * ITEM_CYCLES * 4;
  localparam int STEP_CYCLES  = ARG_W + PROD_W + 2;

  logic     clk;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  operand_t operand = '0;
  logic     busy;
  logic     done;
  result_t  result;
  int       outstanding;
  int       mismatches;
  int       cycles = 0;
  int       words_sent = 0;

  binomial_coefficient_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .operand (operand),
    .done    (done),
    .result  (result)
  );

  coefficient_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .operand     (operand),
    .done        (done),
    .result      (result),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles", cycles);
      $display("binomial_coefficient_unit_tb failed");
      $finish;
    end
  end

  function automatic operand_t pair(input int n, input int k);
    operand_t w;
    w.n = ARG_W'(n);
    w.k = ARG_W'(k);
    return w;
  endfunction

  // Returns at the accepting edge with start still high; the caller either
  // issues the next word or lowers start in that same step
  task automatic issue(input operand_t w);
    int gap;
    gap = (((words_sent / 12) % 4) == 3) ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    operand <= w;
    do @(posedge clk); while (busy);
    words_sent++;
  endtask

  // Hold off until every queued word has produced its result
  task automatic wait_empty();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    operand_t w;
    int sel, n, d;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: trivial k, range errors, extremes, largest exact and first overflows
    issue(pair(0, 0));
    issue(pair(7, 0));
    issue(pair(7, 7));
    issue(pair(0, 1));
    issue(pair(3, 5));
    issue(pair(ARG_MAX - 1, ARG_MAX));
    issue(pair(0, ARG_MAX));
    issue(pair(ARG_MAX, ARG_MAX));
    issue(pair(ARG_MAX, 0));
    issue(pair(ARG_MAX, 1));
    issue(pair(ARG_MAX, ARG_MAX - 1));
    issue(pair(ARG_MAX, 2));
    issue(pair(ARG_MAX, 4));
    issue(pair(ARG_MAX, 5));
    issue(pair(ARG_MAX, ARG_MAX / 2));
    issue(pair(ARG_MAX, ARG_MAX / 2 + 1));
    issue(pair(67, 33));
    issue(pair(68, 34));
    issue(pair(66, 34));
    issue(pair(62, 31));
    issue(pair(1, 0));
    issue(pair(1, 1));
    issue(pair(2, 1));
    issue(pair(30, 15));
    issue(pair(100, 3));
    wait_empty();

    // Random: mostly valid pairs with k <= n, plus range errors and raw words
    for (int idx = 0; idx < RANDOM_WORDS; idx++) begin
      sel = $urandom_range(0, 9);
      if (sel <= 3) begin
        n = $urandom_range(0, 90);
        w = pair(n, $urandom_range(0, n));
      end else if (sel <= 5) begin
        n = $urandom_range(0, ARG_MAX);
        d = $urandom_range(0, 8);
        if (d > n) d = n;
        w = pair(n, ($urandom_range(0, 1) != 0) ? d : n - d);
      end else if (sel <= 7) begin
        n = $urandom_range(0, ARG_MAX - 1);
        w = pair(n, $urandom_range(n + 1, ARG_MAX));
      end else begin
        w.n = ARG_W'($urandom);
        w.k = ARG_W'($urandom);
      end
      issue(w);
      if (idx % 40 == 39) wait_empty();
    end

    // Drain, then leave room for any stray result
    wait_empty();
    repeat (4 * STEP_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("binomial_coefficient_unit_tb passed");
    end else begin
      $display("binomial_coefficient_unit_tb failed");
    end
    $finish;
  end

endmodule

>>> files.f
design/bc_pkg.sv
design/binomial_coefficient_unit.sv
test/coefficient_checker.sv
test/binomial_coefficient_unit_tb.sv
